// File: rtl/aircp_pkg.sv
// Package for the ordered array block: sizes, derived widths and codes.
// Used by the request/response interfaces and by the top level; no dependencies.
package aircp_pkg;

    // Storage size and word width.
    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;

    // Derived widths: entry address, length counter, position compare.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_PAL    = 2'd3
    } t_op;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

endpackage

// File: rtl/aircp_req_if.sv
// Request channel interface: valid/ready handshake with op, position and value.
// Depends on aircp_pkg for the op code type.
interface aircp_req_if;
    logic              valid;
    logic              ready;
    aircp_pkg::t_op    op;
    logic [6:0]        position;
    logic signed [31:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

// File: rtl/aircp_rsp_if.sv
// Response channel interface: valid/ready handshake with the result fields.
// Depends on aircp_pkg for the status code type.
interface aircp_rsp_if;
    logic               valid;
    logic               ready;
    logic [6:0]         match_count;
    logic               is_palindrome;
    logic [6:0]         current_length;
    aircp_pkg::t_status status;

    modport source (output valid, output match_count, output is_palindrome,
                    output current_length, output status, input ready);
    modport sink   (input valid, input match_count, input is_palindrome,
                    input current_length, input status, output ready);
endinterface

// File: rtl/aircp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module aircp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/array_insert_remove_count_palindrome.sv
// Ordered array with insert, remove, count and palindrome check, one request at a time.
// Insert shifts the entries from the end down to the position up by one, then writes the value;
// remove shifts the entries after the position down by one; count reads every entry once;
// palindrome compares both ends pair by pair (two reads per pair); an error or nothing to read
// goes straight to the result. The next request is taken once the result is registered; a result
// waits there until the previous one is taken. Reset clears the length only, not the entry RAM.
module array_insert_remove_count_palindrome (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aircp_req_if.sink       i_req,
    aircp_rsp_if.source     o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_REM,
        S_SCAN,
        S_PAL,
        S_PUT,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                               r_state;
    logic [aircp_pkg::CNT_W-1:0]          r_len;
    aircp_pkg::t_op                       r_op;
    logic [aircp_pkg::ADDR_W-1:0]         r_pos;
    logic [aircp_pkg::VALUE_BITS-1:0]     r_val;
    logic [aircp_pkg::ADDR_W-1:0]         r_idx;
    logic [aircp_pkg::ADDR_W-1:0]         r_last;
    logic                                 r_phase;
    logic                                 r_pend;
    logic                                 r_pend_hi;
    logic [aircp_pkg::ADDR_W-1:0]         r_pend_addr;
    logic [aircp_pkg::VALUE_BITS-1:0]     r_lo_data;
    logic [aircp_pkg::CNT_W-1:0]          r_cnt;
    logic                                 r_pal;
    aircp_pkg::t_status                   r_status;
    logic                                 r_ov;
    logic [6:0]                           r_o_count;
    logic                                 r_o_pal;
    logic [6:0]                           r_o_len;
    aircp_pkg::t_status                   r_o_status;

    logic [aircp_pkg::CMP_W-1:0]          w_pos;
    logic [aircp_pkg::CMP_W-1:0]          w_len;
    logic [aircp_pkg::VALUE_BITS-1:0]     w_val;
    logic [63:0]                          w_val_ext;
    logic                                 w_accept;
    logic                                 w_wr_en;
    logic [aircp_pkg::ADDR_W-1:0]         w_wr_addr;
    logic [aircp_pkg::VALUE_BITS-1:0]     w_wr_data;
    logic [aircp_pkg::ADDR_W-1:0]         w_rd_addr;
    logic [aircp_pkg::VALUE_BITS-1:0]     w_rd_data;
    logic [aircp_pkg::ADDR_W:0]           w_lo_next2;

    // Request fields brought to common widths; the value is sign-extended, then cut.
    assign w_pos     = (aircp_pkg::CMP_W)'(i_req.position);
    assign w_len     = (aircp_pkg::CMP_W)'(r_len);
    assign w_val_ext = {{32{i_req.value[31]}}, i_req.value};
    assign w_val     = w_val_ext[aircp_pkg::VALUE_BITS-1:0];
    assign w_accept  = i_req.valid && i_req.ready;
    assign w_lo_next2 = {1'b0, r_idx} + (aircp_pkg::ADDR_W + 1)'(2);

    assign i_req.ready = (r_state == S_IDLE);

    // Read address: the palindrome walk alternates between the low and high ends.
    assign w_rd_addr = (r_state == S_PAL && r_phase) ? r_last : r_idx;

    // Write port: a shifted entry from the read pipeline, or the inserted value.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pend_addr;
        w_wr_data = w_rd_data;
        if (r_pend && (r_op == aircp_pkg::OP_INSERT || r_op == aircp_pkg::OP_REMOVE)) begin
            w_wr_en = 1'b1;
        end else if (r_state == S_PUT && !r_pend) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_pos;
            w_wr_data = r_val;
        end
    end

    aircp_ram #(
        .WIDTH (aircp_pkg::VALUE_BITS),
        .DEPTH (aircp_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer, read pipeline bookkeeping and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            // Read data arriving this cycle: compare for count and palindrome.
            if (r_pend && r_op == aircp_pkg::OP_COUNT && w_rd_data == r_val) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_pend && r_op == aircp_pkg::OP_PAL) begin
                if (!r_pend_hi) begin
                    r_lo_data <= w_rd_data;
                end else if (w_rd_data != r_lo_data) begin
                    r_pal <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= i_req.op;
                        r_val    <= w_val;
                        r_pos    <= (aircp_pkg::ADDR_W)'(i_req.position);
                        r_cnt    <= '0;
                        r_pal    <= (i_req.op == aircp_pkg::OP_PAL);
                        r_status <= aircp_pkg::STAT_OK;
                        r_last   <= (aircp_pkg::ADDR_W)'(r_len - 1'b1);
                        r_phase  <= 1'b0;
                        r_state  <= S_FINISH;
                        case (i_req.op)
                            aircp_pkg::OP_INSERT: begin
                                if (w_pos > w_len) begin
                                    r_status <= aircp_pkg::STAT_RANGE;
                                end else if (r_len == (aircp_pkg::CNT_W)'(aircp_pkg::DEPTH)) begin
                                    r_status <= aircp_pkg::STAT_FULL;
                                end else begin
                                    r_len <= r_len + 1'b1;
                                    r_idx <= (aircp_pkg::ADDR_W)'(r_len - 1'b1);
                                    r_state <= (w_pos == w_len) ? S_PUT : S_INS;
                                end
                            end
                            aircp_pkg::OP_REMOVE: begin
                                if (w_pos >= w_len) begin
                                    r_status <= aircp_pkg::STAT_RANGE;
                                end else begin
                                    r_len <= r_len - 1'b1;
                                    r_idx <= (aircp_pkg::ADDR_W)'(i_req.position) + 1'b1;
                                    if (w_pos != w_len - 1'b1) begin
                                        r_state <= S_REM;
                                    end
                                end
                            end
                            aircp_pkg::OP_COUNT: begin
                                r_idx <= '0;
                                if (r_len != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_idx <= '0;
                                if (r_len > (aircp_pkg::CNT_W)'(1)) begin
                                    r_state <= S_PAL;
                                end
                            end
                        endcase
                    end
                end

                // Shift up: read entry idx, write it to idx+1, walking down to the position.
                S_INS: begin
                    r_pend      <= 1'b1;
                    r_pend_addr <= r_idx + 1'b1;
                    if (r_idx == r_pos) begin
                        r_state <= S_PUT;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end

                // Shift down: read entry idx, write it to idx-1, walking up to the end.
                S_REM: begin
                    r_pend      <= 1'b1;
                    r_pend_addr <= r_idx - 1'b1;
                    if (r_idx == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end

                // Count: read every held entry once.
                S_SCAN: begin
                    r_pend <= 1'b1;
                    if (r_idx == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end

                // Palindrome: read low end, then high end, then step both inward.
                S_PAL: begin
                    r_pend    <= 1'b1;
                    r_pend_hi <= r_phase;
                    r_phase   <= !r_phase;
                    if (r_phase) begin
                        if (w_lo_next2 < {1'b0, r_last}) begin
                            r_idx  <= r_idx + 1'b1;
                            r_last <= r_last - 1'b1;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end
                end

                // The inserted value goes in once the last shifted entry is written.
                S_PUT: begin
                    if (!r_pend) begin
                        r_state <= S_FINISH;
                    end
                end

                // Let the last read complete.
                S_DRAIN: begin
                    if (!r_pend) begin
                        r_state <= S_FINISH;
                    end
                end

                // Hand the result to the output register once it is free.
                S_FINISH: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov       <= 1'b1;
                        r_o_count  <= 7'(r_cnt);
                        r_o_pal    <= r_pal;
                        r_o_len    <= 7'(r_len);
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.match_count    = r_o_count;
    assign o_rsp.is_palindrome  = r_o_pal;
    assign o_rsp.current_length = r_o_len;
    assign o_rsp.status         = r_o_status;

endmodule
